// ----- sv/mrfc_pkg.sv -----
package mrfc_pkg;

	localparam int FRAME_BYTES = 25;
	localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
	localparam int IDX_W       = $clog2(FRAME_BYTES);
	// highest reading byte index is 20, so readings span bytes 0..20
	localparam int READ_BYTES  = 21;

	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'hA001;
	localparam logic [15:0] TIMEOUT_RESET = 16'd100;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_BYTE  = 2'd1,
		ACT_TICK  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_CRC_ERR = 2'd1,
		ST_TIMEOUT = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] voltage_decivolts;
		logic [31:0] current_milliamps;
		logic [31:0] power_deciwatts;
		logic [31:0] energy_wh;
		logic [15:0] freq_decihertz;
		logic [15:0] power_factor_centi;
	} result_t;

	typedef struct packed {
		logic    load;
		result_t res;
	} res_xfer_t;

endpackage

// ----- sv/mrfc_crc16.sv -----
module mrfc_crc16 (
	input  logic [15:0] crc,
	input  logic [7:0]  data,
	output logic [15:0] crc_next
);
	import mrfc_pkg::*;

	logic [15:0] c;

	always_comb begin
		c = crc ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_next = c;
	end

endmodule

// ----- sv/mrfc_capture.sv -----
module mrfc_capture (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           action,
	input  logic [7:0]           rx_byte,
	input  logic [15:0]          timeout_ticks,
	input  logic                 out_free,
	output mrfc_pkg::res_xfer_t  xfer
);
	import mrfc_pkg::*;

	logic              valid_s1;
	logic [1:0]        action_s1;
	logic [7:0]        byte_s1;

	logic [CNT_W-1:0]  count_q;
	logic [15:0]       elapsed_q;
	logic [15:0]       crc_q;
	logic              capturing_q;
	logic [7:0]        store_q [FRAME_BYTES];

	logic [15:0]       crc_upd;
	logic [15:0]       crc_next;
	logic [15:0]       elapsed_next;
	logic [15:0]       recv_crc;
	logic              feed;
	logic              last;
	logic              produce;
	logic              adv;
	logic [7:0]        view [READ_BYTES];
	result_t           res;

	mrfc_crc16 u_crc (
		.crc      (crc_q),
		.data     (byte_s1),
		.crc_next (crc_upd)
	);

	assign feed         = count_q < CNT_W'(FRAME_BYTES - 2);
	assign last         = count_q == CNT_W'(FRAME_BYTES - 1);
	assign crc_next     = feed ? crc_upd : crc_q;
	assign elapsed_next = elapsed_q + 16'd1;
	assign recv_crc     = {byte_s1, store_q[FRAME_BYTES - 2]};

	// frame as seen on the last byte: stored bytes plus the one arriving now
	always_comb begin
		for (int i = 0; i < READ_BYTES; i++) begin
			if (i < FRAME_BYTES - 1) begin
				view[i] = store_q[IDX_W'((i < FRAME_BYTES) ? i : 0)];
			end else if (i == FRAME_BYTES - 1) begin
				view[i] = byte_s1;
			end else begin
				view[i] = 8'h00;
			end
		end
	end

	always_comb begin
		produce = 1'b0;
		res     = '0;
		unique case (action_s1)
			ACT_START: begin
				produce    = timeout_ticks == 16'd0;
				res.status = ST_TIMEOUT;
			end
			ACT_BYTE: begin
				produce = capturing_q && last;
				if (recv_crc != crc_next) begin
					res.status = ST_CRC_ERR;
				end else begin
					res.status             = ST_OK;
					res.voltage_decivolts  = {view[3], view[4]};
					res.current_milliamps  = {view[7], view[8], view[5], view[6]};
					res.power_deciwatts    = {view[11], view[12], view[9], view[10]};
					res.energy_wh          = {view[15], view[16], view[13], view[14]};
					res.freq_decihertz     = {view[17], view[18]};
					res.power_factor_centi = {view[19], view[20]};
				end
			end
			ACT_TICK: begin
				produce    = capturing_q && (elapsed_next >= timeout_ticks);
				res.status = ST_TIMEOUT;
			end
			default: begin
				produce = 1'b0;
			end
		endcase
		produce = produce && valid_s1;
	end

	// hold the item in stage 1 while its result cannot be placed
	assign adv      = !produce || out_free;
	assign in_stall = valid_s1 && !adv;

	assign xfer.load = produce && adv;
	assign xfer.res  = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1 <= action;
			byte_s1   <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			elapsed_q   <= '0;
			crc_q       <= CRC_INIT;
			capturing_q <= 1'b0;
		end else if (valid_s1 && adv) begin
			case (action_s1)
				ACT_START: begin
					count_q     <= '0;
					elapsed_q   <= '0;
					crc_q       <= CRC_INIT;
					capturing_q <= timeout_ticks != 16'd0;
				end
				ACT_BYTE: begin
					if (capturing_q) begin
						crc_q   <= crc_next;
						count_q <= count_q + CNT_W'(1);
						if (last) begin
							capturing_q <= 1'b0;
						end
					end
				end
				ACT_TICK: begin
					if (capturing_q) begin
						elapsed_q <= elapsed_next;
						if (elapsed_next >= timeout_ticks) begin
							capturing_q <= 1'b0;
						end
					end
				end
				default: begin
					capturing_q <= capturing_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv && action_s1 == ACT_BYTE && capturing_q) begin
			store_q[count_q[IDX_W-1:0]] <= byte_s1;
		end
	end

	// a full frame leaves the count at the frame length until the next start
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FRAME_BYTES))
		else $error("byte count ran past the frame length");

	a_byte_result_last: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer.load && action_s1 == ACT_BYTE) |-> (count_q == CNT_W'(FRAME_BYTES - 1)))
		else $error("byte result before the last frame byte");

	a_result_ends_capture: assert property (@(posedge clk) disable iff (!arst_n)
		xfer.load |=> !capturing_q)
		else $error("capture still armed after a result");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> (valid_s1 && $stable(action_s1) && $stable(byte_s1)))
		else $error("stage 1 item lost while stalled");

endmodule

// ----- sv/mrfc_out.sv -----
module mrfc_out (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mrfc_pkg::res_xfer_t  xfer,
	output logic                 out_free,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mrfc_pkg::result_t    res
);
	import mrfc_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign out_free  = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= xfer.load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && xfer.load) begin
			res_q <= xfer.res;
		end
	end

endmodule

// ----- sv/modbus_reply_frame_checker.sv -----
// Checks a 25-byte energy meter reply framed as Modbus RTU. A start item arms
// capture (with a zero timeout it reports a timeout at once); received bytes
// are stored and run through CRC-16/Modbus, and ticks count toward
// reply_timeout_ticks. One item is taken every clock cycle; each item passes
// an input stage and then the result register. Only a stalled result
// register holds up the input, and only when the item waiting in the input
// stage would itself produce a result. The byte-wide CRC update is the longest
// path. Write reply_timeout_ticks only while no capture is in progress.
module modbus_reply_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] voltage_decivolts,
	output logic [31:0] current_milliamps,
	output logic [31:0] power_deciwatts,
	output logic [31:0] energy_wh,
	output logic [15:0] freq_decihertz,
	output logic [15:0] power_factor_centi,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] reply_timeout_ticks
);
	import mrfc_pkg::*;

	logic [15:0] timeout_q;
	logic        out_free;
	res_xfer_t   xfer;
	result_t     res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= reply_timeout_ticks;
		end
	end

	mrfc_capture u_capture (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.rx_byte       (rx_byte),
		.timeout_ticks (timeout_q),
		.out_free      (out_free),
		.xfer          (xfer)
	);

	mrfc_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.xfer      (xfer),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign status             = res.status;
	assign voltage_decivolts  = res.voltage_decivolts;
	assign current_milliamps  = res.current_milliamps;
	assign power_deciwatts    = res.power_deciwatts;
	assign energy_wh          = res.energy_wh;
	assign freq_decihertz     = res.freq_decihertz;
	assign power_factor_centi = res.power_factor_centi;

endmodule
